// File: src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, types and the CORDIC arctangent table for the quaternion
// to Euler converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QW       = 16;   // quaternion component width, Q2.14
  localparam int PW       = 32;   // product width, Q4.28
  localparam int VW       = 38;   // CORDIC vector width, covers gain and growth
  localparam int ZW       = 33;   // angle accumulator, 1/65536 centidegree
  localparam int AW       = 17;   // rounded angle, centidegrees
  localparam int NW       = 58;   // square-root radicand width
  localparam int RW       = 29;   // square-root result width
  localparam int SQ_STEPS = 29;   // one result bit per step
  localparam int TAB_LEN  = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [ZW-1:0] HALF_TURN  = 33'sd1179648000;
  localparam logic signed [VW-1:0] ONE_Q28    = 38'sd268435456;
  localparam logic signed [AW-1:0] CD_90      = 17'sd9000;
  localparam logic signed [AW-1:0] CD_180     = 17'sd18000;
  localparam logic signed [AW-1:0] CD_360     = 17'sd36000;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [AW-1:0] ang_t;

  // operands carried alongside the square-root pipe
  typedef struct packed {
    vec_t rx;
    vec_t ry;
    vec_t yx;
    vec_t yy;
    vec_t sp;
    logic cl_hi;
    logic cl_lo;
  } side_t;

  // atan(2^-i) in units of 1/65536 centidegree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 33'sd294912000;
      1:       v = 33'sd174096719;
      2:       v = 33'sd91987925;
      3:       v = 33'sd46694507;
      4:       v = 33'sd23437865;
      5:       v = 33'sd11730358;
      6:       v = 33'sd5866610;
      7:       v = 33'sd2933484;
      8:       v = 33'sd1466764;
      9:       v = 33'sd733385;
      10:      v = 33'sd366693;
      11:      v = 33'sd183346;
      12:      v = 33'sd91673;
      13:      v = 33'sd45837;
      14:      v = 33'sd22918;
      15:      v = 33'sd11459;
      16:      v = 33'sd5730;
      17:      v = 33'sd2865;
      18:      v = 33'sd1432;
      19:      v = 33'sd716;
      20:      v = 33'sd358;
      21:      v = 33'sd179;
      22:      v = 33'sd90;
      23:      v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels for quaternion input and Euler angle results.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_cdeg;
  logic signed [14:0] pitch_cdeg;
  logic signed [15:0] roll_cdeg;
  logic               pitch_clamped;

  modport source (output valid, yaw_cdeg, pitch_cdeg, roll_cdeg, pitch_clamped,
                  input ready);
  modport sink   (input valid, yaw_cdeg, pitch_cdeg, roll_cdeg, pitch_clamped,
                  output ready);
endinterface

// File: src/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion (Q2.14) to ZYX yaw, pitch and roll in centidegrees.
// ----------------------------------------------------------------------------
// Takes one quaternion per cycle and returns yaw, pitch and roll in 0.01 deg,
// plus a flag when pitch was clamped at +-90 deg. Fully pipelined: one
// transfer in and one out per clock while out_ready allows, through 3
// product/sum stages, 30 square-root stages for the pitch cosine,
// CORDIC_STAGES + 2 CORDIC stages and 1 output stage. The square-root pipe
// makes one result bit per stage. The whole pipe holds on out_ready low with
// a full output register; in_ready is high on out_ready or an empty output.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  qte_in_if.sink    in_q,
  qte_out_if.source out_e
);
  import qte_pkg::*;

  localparam int FLAG_DLY = CORDIC_STAGES + 2;

  logic          adv;          // pipeline advance
  logic          pv_vld, sq_vld, c_vld;
  logic [NW-1:0] s2;
  side_t         pside, sside;
  logic [RW-1:0] root;
  ang_t          roll_a, yaw_a, pitch_a;
  logic [FLAG_DLY-1:0] hi_d_r, lo_d_r;

  logic                    out_vld_r;
  logic signed [15:0]      yaw_r, roll_r;
  logic signed [14:0]      pitch_r;
  logic                    clamp_r;
  ang_t                    yaw_w, roll_w, pitch_c;

  // Output register doubles as the last stage: move when it is free or taken
  assign adv        = out_e.ready || !out_vld_r;
  assign in_q.ready = adv;

  // Products, their sums and the squared sine term
  qte_prod u_prod (
    .clk, .rst_n, .en(adv),
    .in_vld (in_q.valid),
    .q0     (in_q.quat_w),
    .q1     (in_q.quat_x),
    .q2     (in_q.quat_y),
    .q3     (in_q.quat_z),
    .out_vld(pv_vld),
    .s2     (s2),
    .side   (pside)
  );

  // cos(pitch) = sqrt(1 - sin^2), roll/yaw operands ride alongside
  qte_isqrt u_isqrt (
    .clk, .rst_n, .en(adv),
    .in_vld  (pv_vld),
    .s2      (s2),
    .in_side (pside),
    .out_vld (sq_vld),
    .root    (root),
    .out_side(sside)
  );

  // Three CORDICs in lockstep; roll's valid stands for all
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk, .rst_n, .en(adv),
    .in_vld (sq_vld),
    .x      (sside.rx),
    .y      (sside.ry),
    .out_vld(c_vld),
    .angle  (roll_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk, .rst_n, .en(adv),
    .in_vld (sq_vld),
    .x      (sside.yx),
    .y      (sside.yy),
    .out_vld(),
    .angle  (yaw_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk, .rst_n, .en(adv),
    .in_vld (sq_vld),
    .x      (VW'(root)),
    .y      (sside.sp),
    .out_vld(),
    .angle  (pitch_a)
  );

  // Clamp flags delayed to line up with the CORDIC outputs
  always_ff @(posedge clk) begin
    if (adv) begin
      hi_d_r <= {hi_d_r[FLAG_DLY-2:0], sside.cl_hi};
      lo_d_r <= {lo_d_r[FLAG_DLY-2:0], sside.cl_lo};
    end
  end

  // Wrap past half a turn; pitch limited, or forced when the sine saturated
  always_comb begin
    yaw_w  = yaw_a;
    roll_w = roll_a;
    if (yaw_a > CD_180)   yaw_w  = yaw_a - CD_360;
    if (yaw_a < -CD_180)  yaw_w  = yaw_a + CD_360;
    if (roll_a > CD_180)  roll_w = roll_a - CD_360;
    if (roll_a < -CD_180) roll_w = roll_a + CD_360;
    if (hi_d_r[FLAG_DLY-1]) begin
      pitch_c = CD_90;
    end else if (lo_d_r[FLAG_DLY-1]) begin
      pitch_c = -CD_90;
    end else if (pitch_a > CD_90) begin
      pitch_c = CD_90;
    end else if (pitch_a < -CD_90) begin
      pitch_c = -CD_90;
    end else begin
      pitch_c = pitch_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= c_vld;
    end
    if (adv) begin
      yaw_r   <= yaw_w[15:0];
      roll_r  <= roll_w[15:0];
      pitch_r <= pitch_c[14:0];
      clamp_r <= hi_d_r[FLAG_DLY-1] | lo_d_r[FLAG_DLY-1];
    end
  end

  assign out_e.valid         = out_vld_r;
  assign out_e.yaw_cdeg      = yaw_r;
  assign out_e.pitch_cdeg    = pitch_r;
  assign out_e.roll_cdeg     = roll_r;
  assign out_e.pitch_clamped = clamp_r;

endmodule

// File: src/qte_prod.sv
// ----------------------------------------------------------------------------
// qte_prod
// Three-stage front end: component products, product sums, sine squared.
// ----------------------------------------------------------------------------
module qte_prod (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [15:0]     q0,
  input  logic signed [15:0]     q1,
  input  logic signed [15:0]     q2,
  input  logic signed [15:0]     q3,
  output logic                   out_vld,
  output logic [qte_pkg::NW-1:0] s2,
  output qte_pkg::side_t         side
);
  import qte_pkg::*;

  logic [2:0] vld_r;
  logic signed [PW-1:0] p01_r, p23_r, p11_r, p22_r, p03_r, p12_r, p33_r, p02_r, p31_r;
  side_t sum_r, side_r;
  side_t sum_nxt, side_nxt;
  logic [NW-1:0] s2_r;
  logic signed [RW-1:0] sp_lo;
  logic signed [2*RW-1:0] sq;

  function automatic vec_t ext(input logic signed [PW-1:0] v);
    return vec_t'(v);
  endfunction

  always_comb begin
    sum_nxt.ry = (ext(p01_r) + ext(p23_r)) <<< 1;
    sum_nxt.rx = ONE_Q28 - ((ext(p11_r) + ext(p22_r)) <<< 1);
    sum_nxt.yy = (ext(p03_r) + ext(p12_r)) <<< 1;
    sum_nxt.yx = ONE_Q28 - ((ext(p22_r) + ext(p33_r)) <<< 1);
    sum_nxt.sp = (ext(p02_r) - ext(p31_r)) <<< 1;
    sum_nxt.cl_hi = 1'b0;
    sum_nxt.cl_lo = 1'b0;
  end

  // |sine| < 1.0 once not clamped, so the low 29 bits hold it exactly
  assign sp_lo = sum_r.sp[RW-1:0];
  assign sq    = (2*RW)'(sp_lo) * (2*RW)'(sp_lo);

  always_comb begin
    side_nxt       = sum_r;
    side_nxt.cl_hi = (sum_r.sp >= ONE_Q28);
    side_nxt.cl_lo = (sum_r.sp <= -ONE_Q28);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
    if (en) begin
      p01_r  <= PW'(q0) * PW'(q1);
      p23_r  <= PW'(q2) * PW'(q3);
      p11_r  <= PW'(q1) * PW'(q1);
      p22_r  <= PW'(q2) * PW'(q2);
      p03_r  <= PW'(q0) * PW'(q3);
      p12_r  <= PW'(q1) * PW'(q2);
      p33_r  <= PW'(q3) * PW'(q3);
      p02_r  <= PW'(q0) * PW'(q2);
      p31_r  <= PW'(q3) * PW'(q1);
      sum_r  <= sum_nxt;
      side_r <= side_nxt;
      s2_r   <= NW'(sq);
    end
  end

  assign out_vld = vld_r[2];
  assign s2      = s2_r;
  assign side    = side_r;

endmodule

// File: src/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root of (2^56 - s2), one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [qte_pkg::NW-1:0] s2,
  input  qte_pkg::side_t         in_side,
  output logic                   out_vld,
  output logic [qte_pkg::RW-1:0] root,
  output qte_pkg::side_t         out_side
);
  import qte_pkg::*;

  localparam logic [NW-1:0] ONE_Q56 = NW'(1) << 56;

  logic [NW-1:0] n_r   [0:SQ_STEPS];
  logic [NW-1:0] res_r [0:SQ_STEPS];
  side_t         side_r [0:SQ_STEPS];
  logic [SQ_STEPS:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
    if (en) begin
      n_r[0]    <= ONE_Q56 - s2;
      res_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (56 - 2 * k);
    logic [NW-1:0] trial;
    logic          take;
    assign trial = res_r[k] + BIT;
    assign take  = (n_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        n_r[k+1]    <= take ? (n_r[k] - trial) : n_r[k];
        res_r[k+1]  <= take ? ((res_r[k] >> 1) + BIT) : (res_r[k] >> 1);
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[SQ_STEPS];
  assign root     = res_r[SQ_STEPS][RW-1:0];
  assign out_side = side_r[SQ_STEPS];

endmodule

// File: src/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Unrolled vectoring CORDIC giving atan2(y, x) in centidegrees.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  qte_pkg::vec_t  x,
  input  qte_pkg::vec_t  y,
  output logic           out_vld,
  output qte_pkg::ang_t  angle
);
  import qte_pkg::*;

  vec_t                 x_r [0:STAGES];
  vec_t                 y_r [0:STAGES];
  logic signed [ZW-1:0] z_r [0:STAGES];
  logic [STAGES:0]      zero_r;
  logic [STAGES+1:0]    vld_r;
  ang_t                 ang_r;
  logic signed [ZW-1:0] z_rnd;

  // left half-plane: turn by half a turn first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
    if (en) begin
      zero_r[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        x_r[0] <= -x;
        y_r[0] <= -y;
        z_r[0] <= (y >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        x_r[0] <= x;
        y_r[0] <= y;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    vec_t xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + atan_tab(i);
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - atan_tab(i);
        end
      end
    end
  end

  // round to nearest centidegree, ties upward
  assign z_rnd = (z_r[STAGES] + ZW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[STAGES+1] <= 1'b0;
    end else if (en) begin
      vld_r[STAGES+1] <= vld_r[STAGES];
    end
    if (en) begin
      ang_r <= zero_r[STAGES] ? '0 : z_rnd[AW-1:0];
    end
  end

  assign out_vld = vld_r[STAGES+1];
  assign angle   = ang_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
// Quaternions go in over a valid/ready channel and a local integer model
// works out yaw, pitch and roll for each accepted transfer. Every result
// transfer is compared field by field with the oldest pending prediction.
// The stimulus is directed corner cases first, then unit quaternions,
// near-gimbal-lock attitudes and raw bit noise. Both sides idle at random,
// the receiver stalls once for a long stretch and the sender drains once.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PERIOD_NS   = 20;
  localparam int N_STAGES    = 16;               // CORDIC iterations
  localparam int LATENCY     = 36 + N_STAGES;    // pipe depth, from the top
  localparam int TIMEOUT_CYC = 400000;
  localparam int LONG_HOLD   = 300;              // receiver stall, cycles

  localparam longint Q28_ONE  = 64'sd1 << 28;
  localparam longint HALF_REV = 64'sd18000 * 65536;

  // atan(2^-i) in 1/65536 centidegree
  localparam longint ATAN_LUT [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } euler_t;

  logic clk;
  logic rst_n;

  qte_in_if  in_q ();
  qte_out_if out_e ();

  quaternion_to_euler #(.CORDIC_STAGES(N_STAGES)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_q  (in_q),
    .out_e (out_e)
  );

  euler_t expected_angles[$];
  int     n_errors;
  int     hold_cycles;   // set by a test, consumed by the receiver
  bit     src_busy;      // sender does not idle
  bit     snk_busy;      // receiver does not idle

  initial clk = 1'b0;
  always #(PERIOD_NS / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Angle model
  // --------------------------------------------------------------------------
  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // angle of (vx, vy) in centidegrees, vx on the cosine side
  function automatic longint vector_angle(longint vy, longint vx);
    longint acc;
    longint sx;
    longint sy;
    acc = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      // rotate by half a turn first
      acc = (vy >= 0) ? HALF_REV : -HALF_REV;
      vx  = -vx;
      vy  = -vy;
    end
    for (int i = 0; i < N_STAGES && i < 24; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        acc = acc + ATAN_LUT[i];
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        acc = acc - ATAN_LUT[i];
      end
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint wrap_half(longint a);
    if (a > 18000)  a -= 36000;
    if (a < -18000) a += 36000;
    return a;
  endfunction

  function automatic euler_t quat_angles(logic signed [15:0] w, logic signed [15:0] x,
                                         logic signed [15:0] y, logic signed [15:0] z);
    euler_t r;
    longint qw, qx, qy, qz, sinp, cosp, p;
    qw = w; qx = x; qy = y; qz = z;
    r.roll = 16'(wrap_half(vector_angle(2 * (qw * qx + qy * qz),
                                        Q28_ONE - 2 * (qx * qx + qy * qy))));
    r.yaw  = 16'(wrap_half(vector_angle(2 * (qw * qz + qx * qy),
                                        Q28_ONE - 2 * (qy * qy + qz * qz))));
    sinp = 2 * (qw * qy - qz * qx);
    r.clamped = 1'b0;
    if (sinp >= Q28_ONE) begin
      p = 9000;
      r.clamped = 1'b1;
    end else if (sinp <= -Q28_ONE) begin
      p = -9000;
      r.clamped = 1'b1;
    end else begin
      cosp = floor_sqrt((64'd1 << 56) - longint'(sinp * sinp));
      p = vector_angle(sinp, cosp);
      if (p > 9000)  p = 9000;
      if (p < -9000) p = -9000;
    end
    r.pitch = 15'(p);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z);
    int gap;
    gap = src_busy ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_q.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_q.valid  <= 1'b1;
    in_q.quat_w <= w;
    in_q.quat_x <= x;
    in_q.quat_y <= y;
    in_q.quat_z <= z;
    do @(posedge clk); while (!in_q.ready);
    expected_angles.push_back(quat_angles(w, x, y, z));
  endtask

  task automatic end_burst();
    in_q.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random attitude, normalised to 16384
  task automatic send_unit();
    longint c[4];
    longint n;
    for (int i = 0; i < 4; i++) c[i] = longint'($urandom_range(0, 32768)) - 16384;
    n = floor_sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    if (n == 0) begin
      c[0] = 16384; n = 16384;
    end
    for (int i = 0; i < 4; i++) c[i] = (c[i] * 16384) / n;
    send_quat(c[0], c[1], c[2], c[3]);
  endtask

  // pitch close to +-90 deg: w and y near 1/sqrt2, x and z small
  task automatic send_gimbal();
    logic signed [15:0] a, b;
    a = 11585 + $urandom_range(0, 6) - 3;
    b = $urandom_range(0, 1) ? a + $urandom_range(0, 2) - 1 : -a;
    send_quat($urandom_range(0, 1) ? a : -a, $urandom_range(0, 40) - 20,
              b, $urandom_range(0, 40) - 20);
  endtask

  task automatic send_noise();
    send_quat($urandom, $urandom, $urandom, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  task automatic report(input string field, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, field, got, want);
    n_errors++;
  endtask

  initial begin : result_side
    int     gap;
    euler_t want;
    out_e.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_e.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = snk_busy ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_e.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_e.ready <= 1'b1;
      do @(posedge clk); while (!(out_e.valid && out_e.ready));
      if (expected_angles.size() == 0) begin
        $display("%0t result transfer with nothing pending", $realtime);
        n_errors++;
      end else begin
        want = expected_angles.pop_front();
        if (out_e.yaw_cdeg !== want.yaw)     report("yaw", out_e.yaw_cdeg, want.yaw);
        if (out_e.pitch_cdeg !== want.pitch) report("pitch", out_e.pitch_cdeg, want.pitch);
        if (out_e.roll_cdeg !== want.roll)   report("roll", out_e.roll_cdeg, want.roll);
        if (out_e.pitch_clamped !== want.clamped)
          report("clamp", out_e.pitch_clamped, want.clamped);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corners();
    send_quat(16384, 0, 0, 0);          // identity
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);          // roll half turn, x arg negative
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, -16384, 0);
    send_quat(0, 0, 0, 16384);          // yaw half turn
    send_quat(0, 0, 0, -16384);
    send_quat(0, 0, 0, 0);              // zero quaternion, every angle zero
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(11585, 0, 11585, 0);      // just below the pitch limit
    send_quat(11586, 0, 11586, 0);      // just above
    send_quat(11586, 0, -11586, 0);     // negative clamp
    send_quat(16384, 0, 8192, 0);       // sine term exactly one
    send_quat(16384, 0, -8192, 0);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(0, 11585, 0, -11585);
    send_quat(-1, 1, -1, 1);
    end_burst();
  endtask

  task automatic test_random_mix(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      send_unit();
      else if (pick < 8) send_gimbal();
      else               send_noise();
    end
    end_burst();
  endtask

  // receiver stalls long enough for the pipe to fill and push back
  task automatic test_backpressure();
    src_busy    = 1'b1;
    hold_cycles = LONG_HOLD;
    repeat (120) send_unit();
    end_burst();
    src_busy = 1'b0;
  endtask

  // sender waits for the pipe to empty, then a burst with no idling at all
  task automatic test_drain_and_burst();
    wait (expected_angles.size() == 0);
    src_busy = 1'b1;
    snk_busy = 1'b1;
    repeat (80) send_unit();
    end_burst();
    src_busy = 1'b0;
    snk_busy = 1'b0;
  endtask

  initial begin : stimulus
    n_errors    = 0;
    hold_cycles = 0;
    src_busy    = 1'b0;
    snk_busy    = 1'b0;
    rst_n       <= 1'b0;
    in_q.valid  <= 1'b0;
    in_q.quat_w <= '0;
    in_q.quat_x <= '0;
    in_q.quat_y <= '0;
    in_q.quat_z <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_random_mix(150);
    test_backpressure();
    test_drain_and_burst();
    test_random_mix(180);

    wait (expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS quaternion_to_euler");
    end else begin
      $display("FAIL quaternion_to_euler");
    end
    $finish;
  end

  initial begin : watchdog
    #(longint'(TIMEOUT_CYC) * PERIOD_NS);
    $display("FAIL quaternion_to_euler");
    $finish;
  end

endmodule
